// ----- rtl/lossless_jpeg_rgb_pixel_encoder_macros.svh -----
// Assertion helpers for the encoder RTL.
`ifndef LOSSLESS_JPEG_RGB_PIXEL_ENCODER_MACROS_SVH
`define LOSSLESS_JPEG_RGB_PIXEL_ENCODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define LJRE_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define LJRE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define LJRE_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg)
`define LJRE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif

`endif

// ----- rtl/ljre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ljre_pkg;

	localparam int unsigned MAX_WIDTH = 4096;
	localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
	localparam int unsigned WID_W     = $clog2(MAX_WIDTH + 1);
	localparam int unsigned NUM_CAT   = 10;
	localparam int unsigned TAB_DEPTH = 2 * NUM_CAT;
	localparam int unsigned TAB_IDX_W = $clog2(TAB_DEPTH);

	typedef logic [8:0] comp_val_t;
	typedef comp_val_t [2:0] pix_t;

	// predictor numbers
	localparam logic [2:0] PRED_LEFT      = 3'd1;
	localparam logic [2:0] PRED_TOP       = 3'd2;
	localparam logic [2:0] PRED_TOPLEFT   = 3'd3;
	localparam logic [2:0] PRED_PLANE     = 3'd4;
	localparam logic [2:0] PRED_LEFT_GRAD = 3'd5;
	localparam logic [2:0] PRED_TOP_GRAD  = 3'd6;

	// register indexes
	localparam logic REG_PREDICTOR  = 1'b0;
	localparam logic REG_LINE_WIDTH = 1'b1;

	// opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	// components
	localparam logic [1:0] COMP_LUMA = 2'd0;
	localparam logic [1:0] COMP_CR   = 2'd2;

	localparam comp_val_t  SEED_VAL = 9'd256;
	localparam logic [3:0] CAT_MAX  = 4'd9;
	localparam logic [4:0] LEN_MAX  = 5'd16;

	typedef struct packed {
		logic        we;
		logic        tsel;
		logic [3:0]  cat;
		logic [15:0] code;
		logic [4:0]  len;
	} tab_wr_t;

	typedef struct packed {
		logic [1:0] comp;
		logic [2:0] sel;
		comp_val_t  cur;
		comp_val_t  left;
		comp_val_t  top;
		comp_val_t  topleft;
	} step_req_t;

	typedef struct packed {
		logic [15:0] prefix_code;
		logic [4:0]  prefix_length;
		logic [8:0]  extra_bits;
		logic [3:0]  extra_length;
	} step_res_t;

endpackage
`default_nettype wire

// ----- rtl/lossless_jpeg_rgb_pixel_encoder.sv -----
// Each pixel is registered, then one coding unit codes its components in order
// into the output register, one per cycle unless the output stalls; the next
// pixel is taken as the last one's Cr is coded. Table-entry beats give no result.
// Reset clears control: predictor 1, width 640, column 0, first row, output empty.
// The row store and code table are not cleared; entries read before written are undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "lossless_jpeg_rgb_pixel_encoder_macros.svh"
module lossless_jpeg_rgb_pixel_encoder
	import ljre_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  red,
	input  wire logic        frame_start,
	input  wire logic        table_select,
	input  wire logic [3:0]  category,
	input  wire logic [15:0] code_value,
	input  wire logic [4:0]  code_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       component,
	output logic [15:0]      prefix_code,
	output logic [4:0]       prefix_length,
	output logic [8:0]       extra_bits,
	output logic [3:0]       extra_length,
	output logic             last
);

	logic [2:0]       pred_sel_q;
	logic [12:0]      line_width_q;
	logic [COL_W-1:0] column_q;
	logic             first_q;
	logic             busy_q;
	logic [1:0]       comp_q;
	pix_t             cur_s1;
	logic [2:0]       sel_s1;
	logic             do_top_s1;
	pix_t             left_q, top_q, tl_q, row0_q;
	logic             out_valid_q;
	step_res_t        out_res_q;
	logic [1:0]       out_comp_q;
	logic             out_last_q;
	logic             skid_valid_q;
	step_res_t        skid_res_q;
	logic [1:0]       skid_comp_q;
	logic             skid_last_q;

	logic [WID_W-1:0] width_eff;
	logic             acc, pix_acc, step_fire, out_free;
	logic [COL_W-1:0] col_cur;
	logic             first_cur;
	logic [WID_W-1:0] col_inc;
	logic             do_top;
	logic [9:0]       luma_sum;
	pix_t             cur, seed, rdata;
	tab_wr_t          tab_wr;
	step_req_t        req;
	step_res_t        res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_sel_q   <= PRED_LEFT;
			line_width_q <= 13'd640;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PREDICTOR:  pred_sel_q   <= cfg_data[2:0];
				REG_LINE_WIDTH: line_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp width, place the pixel in the row, transform colors
	always_comb begin
		if (line_width_q == 13'd0) begin
			width_eff = WID_W'(1);
		end else if (WID_W'(line_width_q) > WID_W'(MAX_WIDTH)) begin
			width_eff = WID_W'(MAX_WIDTH);
		end else begin
			width_eff = WID_W'(line_width_q);
		end
		if (frame_start) begin
			col_cur   = '0;
			first_cur = 1'b1;
		end else if ({1'b0, column_q} >= width_eff) begin
			col_cur   = '0;
			first_cur = 1'b0;
		end else begin
			col_cur   = column_q;
			first_cur = first_q;
		end
		col_inc  = {1'b0, col_cur} + WID_W'(1);
		do_top   = !first_cur && (col_inc < width_eff);
		luma_sum = {2'b00, blue} + {1'b0, green, 1'b0} + {2'b00, red};
		cur[0]   = {1'b0, luma_sum[9:2]};
		cur[1]   = {1'b0, blue} - {1'b0, green} + SEED_VAL;
		cur[2]   = {1'b0, red} - {1'b0, green} + SEED_VAL;
		seed     = first_cur ? {3{SEED_VAL}} : row0_q;
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign step_fire = busy_q && !skid_valid_q;
	assign in_stall  = busy_q && !(step_fire && comp_q == COMP_CR);
	assign acc       = in_valid && !in_stall;
	assign pix_acc   = acc && opcode == OP_PIXEL;

	assign tab_wr = '{we: acc && opcode == OP_TABLE, tsel: table_select, cat: category,
		code: code_value, len: code_length};

	ljre_row_ram u_row_ram (
		.clk   (clk),
		.we    (pix_acc),
		.waddr (col_cur),
		.wdata (cur),
		.re    (pix_acc && do_top),
		.raddr (col_inc[COL_W-1:0]),
		.rdata (rdata)
	);

	assign req = '{comp: comp_q, sel: sel_s1, cur: cur_s1[comp_q], left: left_q[comp_q],
		top: top_q[comp_q], topleft: tl_q[comp_q]};

	ljre_coder u_coder (
		.clk    (clk),
		.tab_wr (tab_wr),
		.req    (req),
		.res    (res)
	);

	// row position and component sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			first_q  <= 1'b1;
			busy_q   <= 1'b0;
			comp_q   <= COMP_LUMA;
		end else begin
			if (pix_acc) begin
				if (col_inc >= width_eff) begin
					column_q <= '0;
					first_q  <= 1'b0;
				end else begin
					column_q <= col_inc[COL_W-1:0];
					first_q  <= first_cur;
				end
				busy_q <= 1'b1;
				comp_q <= COMP_LUMA;
			end else if (step_fire) begin
				if (comp_q == COMP_CR) begin
					busy_q <= 1'b0;
				end else begin
					comp_q <= comp_q + 2'd1;
				end
			end
		end
	end

	// pixel payload and neighbor values; a row start reseeds all three
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			cur_s1    <= cur;
			sel_s1    <= first_cur ? PRED_LEFT : pred_sel_q;
			do_top_s1 <= do_top;
			if (col_cur == '0) begin
				row0_q <= cur;
			end
		end
		if (pix_acc && col_cur == '0) begin
			left_q <= seed;
			top_q  <= seed;
			tl_q   <= seed;
		end else if (step_fire) begin
			tl_q[comp_q]   <= top_q[comp_q];
			left_q[comp_q] <= cur_s1[comp_q];
			if (do_top_s1) begin
				top_q[comp_q] <= rdata[comp_q];
			end
		end
	end

	// output register with a skid slot so the input never waits on out_stall directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (step_fire && !out_free) begin
			skid_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q  <= step_fire || skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_res_q  <= skid_res_q;
				out_comp_q <= skid_comp_q;
				out_last_q <= skid_last_q;
			end else if (step_fire) begin
				out_res_q  <= res;
				out_comp_q <= comp_q;
				out_last_q <= comp_q == COMP_CR;
			end
		end else if (step_fire) begin
			skid_res_q  <= res;
			skid_comp_q <= comp_q;
			skid_last_q <= comp_q == COMP_CR;
		end
	end

	assign out_valid     = out_valid_q;
	assign component     = out_comp_q;
	assign prefix_code   = out_res_q.prefix_code;
	assign prefix_length = out_res_q.prefix_length;
	assign extra_bits    = out_res_q.extra_bits;
	assign extra_length  = out_res_q.extra_length;
	assign last          = out_last_q;

	`LJRE_ASSERT_NOW(a_last_on_cr, clk, arst_n, out_valid && last, component == COMP_CR, "last on wrong beat")
	`LJRE_ASSERT_NEXT(a_pixel_starts, clk, arst_n, pix_acc, busy_q && comp_q == COMP_LUMA, "pixel did not start")
	`LJRE_ASSERT_NOW(a_comp_range, clk, arst_n, busy_q, comp_q != 2'd3, "component index out of range")
	`LJRE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({component, last}), "stalled beat changed")
	`LJRE_ASSERT_NOW(a_skid_behind, clk, arst_n, skid_valid_q, out_valid_q, "skid full with output empty")

endmodule
`default_nettype wire

// ----- rtl/ljre_row_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ljre_row_ram
	import ljre_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [COL_W-1:0] waddr,
	input  wire pix_t             wdata,
	input  wire logic             re,
	input  wire logic [COL_W-1:0] raddr,
	output pix_t                  rdata
);

	pix_t mem [MAX_WIDTH];

	// write one row entry, read one with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ljre_coder.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ljre_coder
	import ljre_pkg::*;
(
	input  wire logic      clk,
	input  wire tab_wr_t   tab_wr,
	input  wire step_req_t req,
	output step_res_t      res
);

	logic [20:0]          code_tab_q [TAB_DEPTH];
	logic [TAB_IDX_W-1:0] wr_idx;
	logic [TAB_IDX_W-1:0] rd_idx;
	logic [4:0]           wr_len;
	logic signed [10:0]   l_s, t_s, tl_s, pred;
	comp_val_t            diff, mag, mant, mask;
	logic [3:0]           cat;
	logic [20:0]          entry;

	// load table entries, drop categories above nine, saturate the length
	always_comb begin
		wr_idx = tab_wr.tsel ? TAB_IDX_W'(tab_wr.cat) + TAB_IDX_W'(NUM_CAT)
			: TAB_IDX_W'(tab_wr.cat);
		wr_len = (tab_wr.len > LEN_MAX) ? LEN_MAX : tab_wr.len;
	end

	always_ff @(posedge clk) begin
		if (tab_wr.we && tab_wr.cat <= CAT_MAX) begin
			code_tab_q[wr_idx] <= {tab_wr.code, wr_len};
		end
	end

	// predict, wrap residual to nine bits, classify, look up the code
	always_comb begin
		l_s  = $signed({2'b00, req.left});
		t_s  = $signed({2'b00, req.top});
		tl_s = $signed({2'b00, req.topleft});
		case (req.sel)
			PRED_LEFT:      pred = l_s;
			PRED_TOP:       pred = t_s;
			PRED_TOPLEFT:   pred = tl_s;
			PRED_PLANE:     pred = l_s + t_s - tl_s;
			PRED_LEFT_GRAD: pred = l_s + ((t_s - tl_s) >>> 1);
			PRED_TOP_GRAD:  pred = t_s + ((l_s - tl_s) >>> 1);
			default:        pred = (l_s + t_s) >>> 1;
		endcase
		diff = req.cur - pred[8:0];
		mag  = diff[8] ? (~diff + 9'd1) : diff;
		cat  = 4'd0;
		for (int i = 0; i < 9; i++) begin
			if (mag[i]) begin
				cat = 4'(i + 1);
			end
		end
		mant   = diff[8] ? (diff - 9'd1) : diff;
		mask   = ~(9'h1FF << cat);
		rd_idx = (req.comp == COMP_LUMA) ? TAB_IDX_W'(cat)
			: TAB_IDX_W'(cat) + TAB_IDX_W'(NUM_CAT);
		entry  = code_tab_q[rd_idx];
		res.prefix_code   = entry[20:5];
		res.prefix_length = entry[4:0];
		res.extra_bits    = mant & mask;
		res.extra_length  = cat;
	end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
import ljre_pkg::*;

typedef struct {
	logic [1:0]  comp;
	logic [15:0] code;
	logic [4:0]  code_len;
	logic [8:0]  extra;
	logic [3:0]  extra_len;
	logic        is_last;
} coded_comp_t;

// Tracks the encoder state and the coded components still owed by the block.
class pixel_code_tracker;
	int          row_mem [4096][3];
	int          left_v [3];
	int          top_v [3];
	int          tl_v [3];
	int          col;
	bit          first_row;
	logic [15:0] tab_code [20];
	logic [4:0]  tab_len [20];
	logic [2:0]  pred_sel;
	logic [12:0] width_reg;
	coded_comp_t pending [$];
	int          errors;
	int          checked;

	function new();
		for (int i = 0; i < 3; i++) begin
			left_v[i] = 256;
			top_v[i] = 256;
			tl_v[i] = 256;
		end
		col = 0;
		first_row = 1;
		pred_sel = 3'd1;
		width_reg = 13'd640;
		errors = 0;
		checked = 0;
	endfunction

	function void set_reg(logic idx, logic [12:0] val);
		if (idx == REG_PREDICTOR)
			pred_sel = val[2:0];
		else
			width_reg = val;
	endfunction

	// Note one accepted input beat and queue the components it produces.
	function void note_input(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic fs, logic tsel, logic [3:0] cat_in, logic [15:0] code, logic [4:0] len);
		int w;
		int s;
		int cur [3];
		int p;
		int diff;
		int mag;
		int cat;
		int extra;
		int idx;
		coded_comp_t e;
		if (op == OP_TABLE) begin
			if (cat_in <= CAT_MAX) begin
				tab_code[tsel * 10 + cat_in] = code;
				tab_len[tsel * 10 + cat_in] = (len > LEN_MAX) ? LEN_MAX : len;
			end
			return;
		end
		w = (width_reg == 0) ? 1 : (width_reg > 4096) ? 4096 : width_reg;
		if (fs) begin
			col = 0;
			first_row = 1;
		end else if (col >= w) begin
			col = 0;
			first_row = 0;
		end
		if (col == 0)
			for (int i = 0; i < 3; i++) begin
				left_v[i] = first_row ? 256 : row_mem[0][i];
				top_v[i] = left_v[i];
				tl_v[i] = left_v[i];
			end
		cur[0] = (b + 2 * g + r) >> 2;
		cur[1] = b - g + 256;
		cur[2] = r - g + 256;
		s = first_row ? 1 : (pred_sel == 0 ? 7 : pred_sel);
		for (int i = 0; i < 3; i++) begin
			case (s)
				PRED_LEFT:      p = left_v[i];
				PRED_TOP:       p = top_v[i];
				PRED_TOPLEFT:   p = tl_v[i];
				PRED_PLANE:     p = left_v[i] + top_v[i] - tl_v[i];
				PRED_LEFT_GRAD: p = left_v[i] + ((top_v[i] - tl_v[i]) >>> 1);
				PRED_TOP_GRAD:  p = top_v[i] + ((left_v[i] - tl_v[i]) >>> 1);
				default:        p = (left_v[i] + top_v[i]) >>> 1;
			endcase
			diff = ((cur[i] - p + 256) & 'h1FF) - 256;
			mag = diff < 0 ? -diff : diff;
			cat = 0;
			while (cat < 9 && (mag >> cat) != 0)
				cat++;
			extra = 0;
			if (cat != 0)
				extra = (diff < 0 ? diff - 1 : diff) & ((1 << cat) - 1);
			idx = (i == 0 ? 0 : 10) + cat;
			e.comp = 2'(i);
			e.code = tab_code[idx];
			e.code_len = tab_len[idx];
			e.extra = 9'(extra);
			e.extra_len = 4'(cat);
			e.is_last = (i == 2);
			pending.push_back(e);
			tl_v[i] = top_v[i];
			if (!first_row && col + 1 < w)
				top_v[i] = row_mem[col + 1][i];
			left_v[i] = cur[i];
			row_mem[col][i] = cur[i];
		end
		col++;
		if (col >= w) begin
			col = 0;
			first_row = 0;
		end
	endfunction

	// Compare one result beat against the oldest owed component.
	function void check_result(coded_comp_t got);
		coded_comp_t e;
		checked++;
		if (pending.size() == 0) begin
			$error("unexpected result beat, component %0d", got.comp);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.comp !== e.comp) begin
			$error("component: expected %0d got %0d", e.comp, got.comp);
			errors++;
		end
		if (got.code !== e.code) begin
			$error("prefix_code: expected %h got %h", e.code, got.code);
			errors++;
		end
		if (got.code_len !== e.code_len) begin
			$error("prefix_length: expected %0d got %0d", e.code_len, got.code_len);
			errors++;
		end
		if (got.extra !== e.extra) begin
			$error("extra_bits: expected %h got %h", e.extra, got.extra);
			errors++;
		end
		if (got.extra_len !== e.extra_len) begin
			$error("extra_length: expected %0d got %0d", e.extra_len, got.extra_len);
			errors++;
		end
		if (got.is_last !== e.is_last) begin
			$error("last: expected %0d got %0d", e.is_last, got.is_last);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_write = 0;
	logic        cfg_index = 0;
	logic [12:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        opcode = 0;
	logic [7:0]  blue = 0;
	logic [7:0]  green = 0;
	logic [7:0]  red = 0;
	logic        frame_start = 0;
	logic        table_select = 0;
	logic [3:0]  category = 0;
	logic [15:0] code_value = 0;
	logic [4:0]  code_length = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  component;
	logic [15:0] prefix_code;
	logic [4:0]  prefix_length;
	logic [8:0]  extra_bits;
	logic [3:0]  extra_length;
	logic        last;

	pixel_code_tracker tracker = new();
	int cycles = 0;
	int tx_max = 0;
	int rx_max = 0;
	int rx_wait = 0;
	int hold_left = 0;
	int pixels_sent = 0;
	int table_writes = 0;

	lossless_jpeg_rgb_pixel_encoder uut (.*);

	always #6 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Check each result beat and draw the stall before the next one.
	always @(posedge clk) begin
		coded_comp_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.comp = component;
			got.code = prefix_code;
			got.code_len = prefix_length;
			got.extra = extra_bits;
			got.extra_len = extra_length;
			got.is_last = last;
			tracker.check_result(got);
			rx_wait = $urandom_range(0, rx_max);
		end
	end

	// Drive the receiver stall; a long hold-off takes priority.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1;
			hold_left--;
		end else if (rx_wait > 0) begin
			out_stall = 1;
			rx_wait--;
		end else begin
			out_stall = 0;
		end
	end

	task automatic write_reg(logic idx, logic [12:0] val);
		@(negedge clk);
		cfg_write = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 0;
		tracker.set_reg(idx, val);
	endtask

	// Offer one beat after a random gap and hold it until accepted.
	task automatic send_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic fs, logic tsel, logic [3:0] cat, logic [15:0] code, logic [4:0] len);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		opcode = op;
		blue = b;
		green = g;
		red = r;
		frame_start = fs;
		table_select = tsel;
		category = cat;
		code_value = code;
		code_length = len;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		tracker.note_input(op, b, g, r, fs, tsel, cat, code, len);
		if (op == OP_PIXEL)
			pixels_sent++;
		else
			table_writes++;
		@(negedge clk);
	endtask

	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
		send_beat(OP_PIXEL, b, g, r, fs, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_entry(logic tsel, logic [3:0] cat, logic [15:0] code, logic [4:0] len);
		send_beat(OP_TABLE, $urandom, $urandom, $urandom, $urandom, tsel, cat, code, len);
	endtask

	// Drop valid, wait for every owed result, then let the pipe settle.
	task automatic drain();
		in_valid = 0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_pixel();
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		b = $urandom;
		g = $urandom;
		r = $urandom;
		// skew toward near-grey pixels now and then so small chroma categories show up
		if ($urandom_range(0, 2) == 0) begin
			g = b + $urandom_range(0, 6) - 3;
			r = b + $urandom_range(0, 6) - 3;
		end
		send_pixel(b, g, r, $urandom_range(0, 19) == 0);
	endtask

	task automatic random_entry();
		logic [3:0] cat;
		cat = $urandom_range(0, 9);
		if ($urandom_range(0, 5) == 0)
			cat = $urandom_range(10, 15);
		send_entry($urandom, cat, $urandom, $urandom);
	endtask

	initial begin
		logic [2:0]  preds [12];
		logic [12:0] widths [12];
		int          count;
		preds = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
		widths = '{13'd3, 13'd1, 13'd5, 13'd2, 13'd4, 13'd8, 13'd3, 13'd0,
			13'd4096, 13'd8191, 13'd6, 13'd7};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Load every table entry, hitting code and length extremes.
		for (int t = 0; t < 2; t++)
			for (int c = 0; c <= 9; c++)
				send_entry(t, c, (c == 0) ? 16'h0000 : (c == 9) ? 16'hFFFF : $urandom,
					(c == 0) ? 5'd0 : (c == 9) ? 5'd16 : $urandom_range(1, 16));
		send_entry(1'b0, 4'd3, 16'h5A5A, 5'd31);
		send_entry(1'b1, 4'd12, 16'h1234, 5'd4);

		// First pixel carries no frame start; then extreme pixels and a frame restart at reset settings.
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
		drain();

		// Random phases over predictor and width settings.
		for (int ph = 0; ph < 12; ph++) begin
			tx_max = (ph % 3 == 1) ? 0 : 6;
			rx_max = (ph % 4 == 2) ? 0 : 6;
			write_reg(REG_PREDICTOR, preds[ph]);
			write_reg(REG_LINE_WIDTH, widths[ph]);
			if (ph == 4)
				hold_left = 120;
			count = (widths[ph] >= 4096) ? 6 : 10;
			send_pixel($urandom, $urandom, $urandom, 1'b1);
			for (int k = 0; k < count; k++)
				if ($urandom_range(0, 7) == 0)
					random_entry();
				else
					random_pixel();
			drain();
		end

		$display("Encoded %0d pixels (%0d result beats) with %0d table writes,",
			pixels_sent, tracker.checked, table_writes);
		$display("across predictors 0-7 and widths from zero to beyond the maximum.");
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
